[sv/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants of the format spec parser
// Character classes, conversion kinds, parse state and the saturating
// decimal append used by the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

	// characters with a meaning of their own
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
	localparam logic [31:0] PREC_NONE = 32'hFFFF_FFFF;
	localparam logic [7:0]  POS_MAX   = 8'hFF;

	typedef enum logic [3:0] {
		KIND_NONE = 4'd0,
		KIND_C    = 4'd1,
		KIND_S    = 4'd2,
		KIND_P    = 4'd3,
		KIND_D    = 4'd4,
		KIND_I    = 4'd5,
		KIND_U    = 4'd6,
		KIND_X    = 4'd7,
		KIND_XU   = 4'd8,
		KIND_PCT  = 4'd9
	} conv_kind_t;

	typedef enum logic [2:0] {
		CLS_TERM,
		CLS_DIGIT,
		CLS_DASH,
		CLS_STAR,
		CLS_DOT,
		CLS_OTHER
	} char_class_t;

	typedef enum logic [1:0] {
		PK_OTHER,
		PK_DIGIT,
		PK_DOT
	} prev_kind_t;

	typedef enum logic [1:0] {
		RK_NONE,
		RK_WIDTH,
		RK_PREC
	} run_kind_t;

	// one classified item, front to back
	typedef struct packed {
		char_class_t        cls;
		conv_kind_t         kind;
		logic [3:0]         digit;
		logic signed [31:0] star_value;
	} entry_t;

	typedef struct packed {
		prev_kind_t  prev;
		run_kind_t   run;
		logic        lone_zero;
		logic        dot_pending;
		logic        align;
		logic        zero;
		logic [30:0] width;
		logic [31:0] prec;
		logic [7:0]  pos;
		logic        sat;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		prev:        PK_OTHER,
		run:         RK_NONE,
		lone_zero:   1'b0,
		dot_pending: 1'b0,
		align:       1'b0,
		zero:        1'b0,
		width:       31'd0,
		prec:        PREC_NONE,
		pos:         8'd0,
		sat:         1'b0
	};

	function automatic conv_kind_t conv_kind_of(input logic [7:0] c);
		conv_kind_t k;
		case (c)
			8'h63:   k = KIND_C;
			8'h73:   k = KIND_S;
			8'h70:   k = KIND_P;
			8'h64:   k = KIND_D;
			8'h69:   k = KIND_I;
			8'h75:   k = KIND_U;
			8'h78:   k = KIND_X;
			8'h58:   k = KIND_XU;
			8'h25:   k = KIND_PCT;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	// acc*10 + d, clipped to VALUE_MAX; bit 31 of the result flags the clip
	function automatic logic [31:0] sat_append(input logic [30:0] acc, input logic [3:0] d);
		logic [34:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
		if (v > {4'd0, VALUE_MAX}) begin
			return {1'b1, VALUE_MAX};
		end else begin
			return {1'b0, v[30:0]};
		end
	endfunction

endpackage

`default_nettype wire

[sv/fsp_if.sv]
// ----------------------------------------------------------------------------
// fsp_if: channel interfaces of the format spec parser
// Character channel in, parsed spec channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsp_in_if;
	logic               valid;
	logic               ready;
	logic [7:0]         char_code;
	logic signed [31:0] star_value;

	modport source (output valid, output char_code, output star_value, input ready);
	modport sink   (input valid, input char_code, input star_value, output ready);
endinterface

interface fsp_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         conv_kind;
	logic [7:0]         conv_position;
	logic               left_align;
	logic               zero_pad;
	logic [30:0]        field_width;
	logic signed [31:0] precision;
	logic               overflow;

	modport source (output valid, output conv_kind, output conv_position,
		output left_align, output zero_pad, output field_width,
		output precision, output overflow, input ready);
	modport sink   (input valid, input conv_kind, input conv_position,
		input left_align, input zero_pad, input field_width,
		input precision, input overflow, output ready);
endinterface

`default_nettype wire

[sv/format_spec_parser.sv]
// ----------------------------------------------------------------------------
// format_spec_parser: printf conversion spec parser
// Collects flags, width and precision of one conversion spec from its
// characters and gives one parsed result per spec.
// ----------------------------------------------------------------------------
// Usage:
//   spec_in carries the characters after a percent sign, one per item, with
//   the star argument alongside (used only for '*'). spec_out carries one
//   item per spec, given at the conversion character or at a NUL; all other
//   characters only update the parse state.
// Throughput: one character per cycle while results are taken. The
//   per-character update is a decode in the front and one x10-and-add with
//   a saturation compare in the back; nothing iterates.
// Path: a terminating character is written into the queue, then the back
//   end takes it and writes the result register, which drives spec_out.
// Stall: the result register holds until taken. While it is full, a further
//   terminator waits at the head of the queue; only characters ahead of it
//   drain. When the queue fills, spec_in.ready drops.
// Reset: arst_n clears the queue, the result register and the parse state
//   (width 0, precision -1, no flags); no clearing pass is needed.
// QUEUE_DEPTH sets the number of entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module format_spec_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	fsp_in_if.sink    spec_in,
	fsp_out_if.source spec_out
);

	logic            push_valid;
	logic            push_ready;
	fsp_pkg::entry_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	fsp_pkg::entry_t pop_data;

	// classify characters
	fsp_front u_front (
		.spec_in    (spec_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouples input acceptance from result stalls
	fsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// parse state update and result register
	fsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.spec_out  (spec_out)
	);

endmodule

`default_nettype wire

[sv/fsp_front.sv]
// ----------------------------------------------------------------------------
// fsp_front: character classifier
// Takes items from the input channel and pushes classified entries.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_front (
	fsp_in_if.sink          spec_in,
	output logic            push_valid,
	input  logic            push_ready,
	output fsp_pkg::entry_t push_data
);

	fsp_pkg::conv_kind_t kind;

	assign kind           = fsp_pkg::conv_kind_of(spec_in.char_code);
	assign push_valid     = spec_in.valid;
	assign spec_in.ready  = push_ready;

	always_comb begin
		push_data.kind       = kind;
		push_data.digit      = spec_in.char_code[3:0];
		push_data.star_value = spec_in.star_value;
		if (spec_in.char_code == fsp_pkg::CH_NUL || kind != fsp_pkg::KIND_NONE) begin
			push_data.cls = fsp_pkg::CLS_TERM;
		end else if (spec_in.char_code >= fsp_pkg::CH_ZERO &&
				spec_in.char_code <= fsp_pkg::CH_NINE) begin
			push_data.cls = fsp_pkg::CLS_DIGIT;
		end else if (spec_in.char_code == fsp_pkg::CH_DASH) begin
			push_data.cls = fsp_pkg::CLS_DASH;
		end else if (spec_in.char_code == fsp_pkg::CH_STAR) begin
			push_data.cls = fsp_pkg::CLS_STAR;
		end else if (spec_in.char_code == fsp_pkg::CH_DOT) begin
			push_data.cls = fsp_pkg::CLS_DOT;
		end else begin
			push_data.cls = fsp_pkg::CLS_OTHER;
		end
	end

endmodule

`default_nettype wire

[sv/fsp_queue.sv]
// ----------------------------------------------------------------------------
// fsp_queue: short entry queue between front and back
// Register-based FIFO; push and pop in the same cycle, also when full.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  fsp_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output fsp_pkg::entry_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	fsp_pkg::entry_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	// a pop frees a slot in the same cycle
	assign push_ready = (count_q != CNT_FULL) || pop_ready;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[sv/fsp_back.sv]
// ----------------------------------------------------------------------------
// fsp_back: parse state and result register
// Applies one classified entry per cycle; a terminator waits while the
// result register is full, then loads it and resets the parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  fsp_pkg::entry_t pop_data,
	fsp_out_if.source       spec_out
);

	fsp_pkg::parse_state_t st_q;
	fsp_pkg::parse_state_t st_d;
	logic        pop;
	logic        term;
	logic [30:0] acc;
	logic [31:0] app;
	logic [31:0] star_mag;
	logic [7:0]  res_pos;

	logic               out_valid_q;
	logic [3:0]         kind_q;
	logic [7:0]         pos_q;
	logic               align_q;
	logic               zero_q;
	logic [30:0]        width_q;
	logic signed [31:0] prec_q;
	logic               ovf_q;

	assign term      = (pop_data.cls == fsp_pkg::CLS_TERM);
	// only a terminator needs room in the result register
	assign pop_ready = !term || !out_valid_q || spec_out.ready;
	assign pop       = pop_valid && pop_ready;

	// one shared x10 append unit for width and precision runs
	assign acc      = (st_q.run == fsp_pkg::RK_PREC) ? st_q.prec[30:0] : st_q.width;
	assign app      = fsp_pkg::sat_append(acc, pop_data.digit);
	assign star_mag = 32'(~pop_data.star_value) + 32'd1;

	// next parse state
	always_comb begin
		st_d = st_q;
		if (pop) begin
			if (!term && st_q.pos != fsp_pkg::POS_MAX) begin
				st_d.pos = st_q.pos + 8'd1;
			end
			case (pop_data.cls)
				fsp_pkg::CLS_TERM: begin
					st_d = fsp_pkg::PARSE_RESET;
				end
				fsp_pkg::CLS_DIGIT: begin
					case (st_q.prev)
						fsp_pkg::PK_DIGIT: begin
							if (st_q.run == fsp_pkg::RK_WIDTH) begin
								if (st_q.lone_zero) begin
									st_d.width     = {27'd0, pop_data.digit};
									st_d.lone_zero = 1'b0;
								end else begin
									st_d.width = app[30:0];
									st_d.sat   = st_q.sat | app[31];
								end
							end else if (st_q.run == fsp_pkg::RK_PREC) begin
								st_d.prec = {1'b0, app[30:0]};
								st_d.sat  = st_q.sat | app[31];
							end
						end
						fsp_pkg::PK_DOT: begin
							st_d.prec = {28'd0, pop_data.digit};
							st_d.run  = fsp_pkg::RK_PREC;
						end
						default: begin
							st_d.run = fsp_pkg::RK_WIDTH;
							if (pop_data.digit == 4'd0) begin
								// lone zero: flag now, width only if a digit follows
								st_d.zero      = 1'b1;
								st_d.lone_zero = 1'b1;
							end else begin
								st_d.width     = {27'd0, pop_data.digit};
								st_d.lone_zero = 1'b0;
							end
						end
					endcase
					st_d.prev        = fsp_pkg::PK_DIGIT;
					st_d.dot_pending = 1'b0;
				end
				default: begin
					if (pop_data.cls == fsp_pkg::CLS_DASH) begin
						st_d.align = 1'b1;
					end else if (pop_data.cls == fsp_pkg::CLS_STAR) begin
						if (st_q.dot_pending) begin
							st_d.prec = pop_data.star_value[31] ? fsp_pkg::PREC_NONE
								: pop_data.star_value;
						end else if (pop_data.star_value[31]) begin
							st_d.align = 1'b1;
							// most negative value has no 31-bit magnitude
							if (star_mag[31]) begin
								st_d.width = fsp_pkg::VALUE_MAX;
								st_d.sat   = 1'b1;
							end else begin
								st_d.width = star_mag[30:0];
							end
						end else begin
							st_d.width = pop_data.star_value[30:0];
						end
					end else if (pop_data.cls == fsp_pkg::CLS_DOT) begin
						st_d.prec = 32'd0;
					end
					st_d.run       = fsp_pkg::RK_NONE;
					st_d.lone_zero = 1'b0;
					if (pop_data.cls == fsp_pkg::CLS_DOT) begin
						st_d.prev        = fsp_pkg::PK_DOT;
						st_d.dot_pending = 1'b1;
					end else begin
						st_d.prev        = fsp_pkg::PK_OTHER;
						st_d.dot_pending = 1'b0;
					end
				end
			endcase
		end
	end

	// result position
	always_comb begin
		res_pos = (st_q.pos == fsp_pkg::POS_MAX) ? fsp_pkg::POS_MAX : st_q.pos + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= fsp_pkg::PARSE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop && term) begin
				out_valid_q <= 1'b1;
			end else if (spec_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && term) begin
			kind_q  <= 4'(pop_data.kind);
			pos_q   <= res_pos;
			align_q <= st_q.align;
			zero_q  <= st_q.zero;
			width_q <= st_q.width;
			prec_q  <= st_q.prec;
			ovf_q   <= st_q.sat;
		end
	end

	assign spec_out.valid         = out_valid_q;
	assign spec_out.conv_kind     = kind_q;
	assign spec_out.conv_position = pos_q;
	assign spec_out.left_align    = align_q;
	assign spec_out.zero_pad      = zero_q;
	assign spec_out.field_width   = width_q;
	assign spec_out.precision     = prec_q;
	assign spec_out.overflow      = ovf_q;

endmodule

`default_nettype wire

[sv/fsp_checker.sv]
// ----------------------------------------------------------------------------
// fsp_checker: port-level checks of the format spec parser
// Result channel handshake and result value sanity, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [3:0]         out_kind,
	input logic [7:0]         out_pos,
	input logic [30:0]        out_width,
	input logic signed [31:0] out_prec
);

	// result item held until taken
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_pos) &&
			$stable(out_width) && $stable(out_prec))
		else $error("result changed while stalled");

	// async reset empties the result register
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// terminator counts at least one character past the percent sign
	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_pos != 8'd0)
		else $error("result position is zero");

	// the only negative precision is the none marker
	a_prec_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_prec[31] |-> out_prec == -32'sd1)
		else $error("negative precision other than none");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (spec_out.valid),
	.out_ready (spec_out.ready),
	.out_kind  (spec_out.conv_kind),
	.out_pos   (spec_out.conv_position),
	.out_width (spec_out.field_width),
	.out_prec  (spec_out.precision)
);

`default_nettype wire
